// ===== src/rle16_pkg.sv =====
// Shared types and constants of the 16-bit pixel run-length decoder.
// No dependencies.
`default_nettype none
package rle16_pkg;

   localparam int unsigned MaxPixels   = 1048576;
   localparam int unsigned FrameW      = 21;
   localparam int unsigned PosW        = 21;
   localparam int unsigned StartW      = 20;
   localparam int unsigned CountW      = 8;
   localparam int unsigned ColorW      = 16;
   localparam int unsigned ByteW       = 8;

   localparam logic [FrameW-1:0] FrameReset = FrameW'(307200);
   localparam logic [FrameW-1:0] FrameMax   = FrameW'(MaxPixels);

   localparam logic KindFill   = 1'b0;
   localparam logic KindMasked = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LOW    = 2'd1,
      PH_HIGH   = 2'd2,
      PH_SKIP   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             frame_kind;
      logic             last_byte;
   } req_item_type;

   typedef struct packed {
      logic              write_valid;
      logic [StartW-1:0] start_pixel;
      logic [CountW-1:0] run_length;
      logic [ColorW-1:0] color;
      logic              frame_end;
      logic              overflow;
   } rsp_item_type;

   typedef struct packed {
      logic valid;
      logic take;
   } stage_ctl_type;

endpackage
`default_nettype wire

// ===== src/rle16_ifs.sv =====
// Channel interfaces of the decoder: request bytes, response runs, frame size register.
// Depends on rle16_pkg.
`default_nettype none
interface rle16_req_if import rle16_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;
   logic             frame_kind;
   logic             last_byte;

   modport source (output valid, data_byte, frame_kind, last_byte, input ready);
   modport sink (input valid, data_byte, frame_kind, last_byte, output ready);
endinterface

interface rle16_rsp_if import rle16_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              write_valid;
   logic [StartW-1:0] start_pixel;
   logic [CountW-1:0] run_length;
   logic [ColorW-1:0] color;
   logic              frame_end;
   logic              overflow;

   modport source (output valid, write_valid, start_pixel, run_length, color, frame_end,
                   overflow, input ready);
   modport sink (input valid, write_valid, start_pixel, run_length, color, frame_end,
                 overflow, output ready);
endinterface

interface rle16_csr_if import rle16_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FrameW-1:0] frame_pixels;

   modport source (output valid, frame_pixels, input ready);
   modport sink (input valid, frame_pixels, output ready);
endinterface
`default_nettype wire

// ===== src/rle16_in_stage.sv =====
// Input register of the decoder: holds one request word until the decode stage takes it.
// Depends on rle16_pkg and rle16_req_if.
`default_nettype none
module rle16_in_stage import rle16_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   rle16_req_if.sink    req_chan,
   input  wire logic    take,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte  <= req_chan.data_byte;
         item_ff.frame_kind <= req_chan.frame_kind;
         item_ff.last_byte  <= req_chan.last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// ===== src/rle16_decode.sv =====
// Decode stage: frame state, run computation and the response register.
// Depends on rle16_pkg and rle16_rsp_if.
`default_nettype none
module rle16_decode import rle16_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire req_item_type      item,
   input  wire logic [FrameW-1:0] frame_pixels,
   output stage_ctl_type          ctl,
   rle16_rsp_if.source            rsp_chan
);

   typedef struct packed {
      phase_type         phase;
      logic [CountW-1:0] literal_left;
      logic              fill_pending;
      logic [CountW-1:0] fill_count;
   } hdr_type;

   phase_type         phase_ff, phase_in;
   logic [CountW-1:0] literal_left_ff, literal_left_in;
   logic              fill_pending_ff, fill_pending_in;
   logic [CountW-1:0] fill_count_ff, fill_count_in;
   logic [ByteW-1:0]  low_latch_ff, low_latch_in;
   logic [PosW-1:0]   pixel_pos_ff, pixel_pos_in;
   logic              stopped_ff, stopped_in;
   logic              overflow_seen_ff, overflow_seen_in;

   logic              rsp_valid_ff;
   rsp_item_type      rsp_ff;
   rsp_item_type      rsp_in;

   logic              take;
   logic [FrameW-1:0] frame_size;
   logic              pos_past;
   logic [PosW-1:0]   room;
   logic [CountW-1:0] fill_len;
   logic              fill_clip;
   hdr_type           hdr;

   function automatic hdr_type take_header(input logic [ByteW-1:0] b, input logic kind,
                                           input logic [CountW-1:0] count_now);
      hdr_type h;
      h.fill_count = count_now;
      if (b[ByteW-1]) begin
         h.literal_left = CountW'(~b + 8'd1);
         h.fill_pending = 1'b0;
         h.phase        = PH_LOW;
      end else if (kind == KindFill) begin
         h.literal_left = '0;
         h.fill_pending = 1'b1;
         h.fill_count   = CountW'(b) + CountW'(2);
         h.phase        = PH_LOW;
      end else begin
         h.literal_left = '0;
         h.fill_pending = 1'b0;
         h.fill_count   = CountW'(b) + CountW'(1);
         h.phase        = PH_SKIP;
      end
      return h;
   endfunction

   assign take          = item_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign ctl.valid     = item_valid;
   assign ctl.take      = take;
   assign frame_size    = (frame_pixels > FrameMax) ? FrameMax : frame_pixels;
   assign pos_past      = pixel_pos_ff >= frame_size;
   assign room          = frame_size - pixel_pos_ff;
   assign fill_clip     = PosW'(fill_count_ff) > room;
   assign fill_len      = fill_clip ? room[CountW-1:0] : fill_count_ff;
   assign hdr           = take_header(item.data_byte, item.frame_kind, fill_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         literal_left_ff  <= '0;
         fill_pending_ff  <= 1'b0;
         fill_count_ff    <= '0;
         low_latch_ff     <= '0;
         pixel_pos_ff     <= '0;
         stopped_ff       <= 1'b0;
         overflow_seen_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (take) begin
            phase_ff         <= phase_in;
            literal_left_ff  <= literal_left_in;
            fill_pending_ff  <= fill_pending_in;
            fill_count_ff    <= fill_count_in;
            low_latch_ff     <= low_latch_in;
            pixel_pos_ff     <= pixel_pos_in;
            stopped_ff       <= stopped_in;
            overflow_seen_ff <= overflow_seen_in;
         end
         rsp_valid_ff <= take || (rsp_valid_ff && !rsp_chan.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      literal_left_in  = literal_left_ff;
      fill_pending_in  = fill_pending_ff;
      fill_count_in    = fill_count_ff;
      low_latch_in     = low_latch_ff;
      pixel_pos_in     = pixel_pos_ff;
      stopped_in       = stopped_ff;
      overflow_seen_in = overflow_seen_ff;
      rsp_in           = '0;

      if (!stopped_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               if (!item.last_byte) begin
                  phase_in        = hdr.phase;
                  literal_left_in = hdr.literal_left;
                  fill_pending_in = hdr.fill_pending;
                  fill_count_in   = hdr.fill_count;
               end
            end
            PH_LOW: begin
               if (item.last_byte) begin
                  stopped_in = 1'b1;
               end else if (!fill_pending_ff && pos_past) begin
                  overflow_seen_in = 1'b1;
                  stopped_in       = 1'b1;
               end else begin
                  low_latch_in = item.data_byte;
                  phase_in     = PH_HIGH;
               end
            end
            PH_HIGH: begin
               if (fill_pending_ff) begin
                  if (pos_past) begin
                     overflow_seen_in = 1'b1;
                     stopped_in       = 1'b1;
                  end else begin
                     rsp_in.write_valid = fill_len != '0;
                     rsp_in.start_pixel = pixel_pos_ff[StartW-1:0];
                     rsp_in.run_length  = fill_len;
                     rsp_in.color       = {item.data_byte, low_latch_ff};
                     pixel_pos_in       = pixel_pos_ff + PosW'(fill_len);
                     if (fill_clip || overflow_seen_ff) begin
                        overflow_seen_in = 1'b1;
                        stopped_in       = 1'b1;
                     end
                  end
                  fill_pending_in = 1'b0;
                  phase_in        = PH_HEADER;
               end else begin
                  rsp_in.write_valid = 1'b1;
                  rsp_in.start_pixel = pixel_pos_ff[StartW-1:0];
                  rsp_in.run_length  = CountW'(1);
                  rsp_in.color       = {item.data_byte, low_latch_ff};
                  pixel_pos_in       = pixel_pos_ff + PosW'(1);
                  literal_left_in    = (literal_left_ff != '0) ?
                                       literal_left_ff - CountW'(1) : literal_left_ff;
                  phase_in           = (literal_left_in != '0) ? PH_LOW : PH_HEADER;
               end
            end
            PH_SKIP: begin
               if (item.last_byte) begin
                  stopped_in = 1'b1;
               end else if (pos_past) begin
                  overflow_seen_in = 1'b1;
                  stopped_in       = 1'b1;
               end else begin
                  pixel_pos_in    = pixel_pos_ff + PosW'(fill_count_ff);
                  phase_in        = hdr.phase;
                  literal_left_in = hdr.literal_left;
                  fill_pending_in = hdr.fill_pending;
                  fill_count_in   = hdr.fill_count;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end

      rsp_in.frame_end = item.last_byte;
      rsp_in.overflow  = overflow_seen_in;

      if (item.last_byte) begin
         phase_in         = PH_HEADER;
         literal_left_in  = '0;
         fill_pending_in  = 1'b0;
         fill_count_in    = '0;
         low_latch_in     = '0;
         pixel_pos_in     = '0;
         stopped_in       = 1'b0;
         overflow_seen_in = 1'b0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.write_valid = rsp_ff.write_valid;
   assign rsp_chan.start_pixel = rsp_ff.start_pixel;
   assign rsp_chan.run_length  = rsp_ff.run_length;
   assign rsp_chan.color       = rsp_ff.color;
   assign rsp_chan.frame_end   = rsp_ff.frame_end;
   assign rsp_chan.overflow    = rsp_ff.overflow;

endmodule
`default_nettype wire

// ===== src/rle16_frame_pixel_decoder_core.sv =====
// Top level of the 16-bit pixel run-length decoder: input register, decode stage,
// frame size register. Depends on rle16_pkg, rle16_ifs, rle16_in_stage, rle16_decode.
//
//   channel    dir   word
//   req_chan   in    data_byte, frame_kind, last_byte
//   rsp_chan   out   write_valid, start_pixel, run_length, color, frame_end, overflow
//   csr_chan   in    frame_pixels (always ready)
//
// One word per cycle sustained while rsp_chan is ready; an accepted word is held in the input
// register, then decoded from the input register into the response register.
// Synchronous reset clears frame state and sets frame_pixels to 307200.
// A stalled response holds the decode stage; the input register still takes one word.
`default_nettype none
module rle16_frame_pixel_decoder_core import rle16_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   rle16_req_if.sink   req_chan,
   rle16_rsp_if.source rsp_chan,
   rle16_csr_if.sink   csr_chan
);

   logic [FrameW-1:0] frame_pixels_ff;
   logic [FrameW-1:0] frame_pixels_in;
   logic              item_valid;
   req_item_type      item;
   stage_ctl_type     ctl;

   assign csr_chan.ready  = 1'b1;
   assign frame_pixels_in = (csr_chan.valid && csr_chan.ready) ?
                            csr_chan.frame_pixels : frame_pixels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= FrameReset;
      end else begin
         frame_pixels_ff <= frame_pixels_in;
      end
   end

   rle16_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (ctl.take),
      .item_valid (item_valid),
      .item       (item)
   );

   rle16_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .frame_pixels (frame_pixels_ff),
      .ctl          (ctl),
      .rsp_chan     (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench of the 16-bit pixel run-length decoder: directed script, then random frames
// checked against a predictor. Depends on rle16_pkg, rle16_ifs, rle16_frame_pixel_decoder_core.
`default_nettype none
module tb_top;
   import rle16_pkg::*;

   localparam int Period     = 8;
   localparam int ResetLen   = 10;
   localparam int DrainPause = 8;
   localparam int HoldCycles = 300;
   localparam int QuietLimit = 4000;
   localparam int PhaseWords = 250;
   localparam int NumPhases  = 8;
   localparam int NumRows    = 34;

   localparam int unsigned PhaseSizes [NumPhases] =
      '{64, 5, 1, 17, 2097151, 300, 0, 1048576};

   localparam rsp_item_type NoRun = '0;

   typedef struct {
      bit           set_size;
      int unsigned  size;
      logic [7:0]   data;
      logic         kind;
      logic         last;
      bit           typed;
      rsp_item_type want;
   } step_row_type;

   step_row_type script_rows [NumRows] = '{
      '{0, 0,       8'h00, KindFill,   0, 1, NoRun},
      '{0, 0,       8'hFF, KindFill,   0, 1, NoRun},
      '{0, 0,       8'hFF, KindFill,   0, 1, '{1, 0, 2, 16'hFFFF, 0, 0}},
      '{0, 0,       8'h7F, KindFill,   0, 1, NoRun},
      '{0, 0,       8'h34, KindFill,   0, 1, NoRun},
      '{0, 0,       8'h12, KindFill,   0, 1, '{1, 2, 129, 16'h1234, 0, 0}},
      '{0, 0,       8'h80, KindFill,   0, 1, NoRun},
      '{0, 0,       8'hAA, KindFill,   0, 1, NoRun},
      '{0, 0,       8'h55, KindFill,   0, 1, '{1, 131, 1, 16'h55AA, 0, 0}},
      '{0, 0,       8'h01, KindFill,   1, 1, '{0, 0, 0, 0, 1, 0}},
      '{0, 0,       8'h05, KindMasked, 0, 1, NoRun},
      '{0, 0,       8'hFF, KindMasked, 0, 0, NoRun},
      '{0, 0,       8'h11, KindMasked, 0, 0, NoRun},
      '{0, 0,       8'h22, KindMasked, 0, 0, NoRun},
      '{0, 0,       8'h03, KindMasked, 0, 1, NoRun},
      '{0, 0,       8'h00, KindMasked, 1, 1, '{0, 0, 0, 0, 1, 0}},
      '{0, 0,       8'h02, KindMasked, 0, 1, NoRun},
      '{0, 0,       8'h01, KindFill,   0, 0, NoRun},
      '{0, 0,       8'hEF, KindFill,   0, 0, NoRun},
      '{0, 0,       8'hBE, KindFill,   1, 0, NoRun},
      '{1, 3,       8'h03, KindFill,   0, 1, NoRun},
      '{0, 0,       8'h0F, KindFill,   0, 1, NoRun},
      '{0, 0,       8'hF0, KindFill,   0, 1, '{1, 0, 3, 16'hF00F, 0, 1}},
      '{0, 0,       8'h00, KindFill,   1, 1, '{0, 0, 0, 0, 1, 1}},
      '{1, 0,       8'h00, KindMasked, 0, 1, NoRun},
      '{0, 0,       8'h00, KindMasked, 0, 1, '{0, 0, 0, 0, 0, 1}},
      '{0, 0,       8'h00, KindFill,   1, 1, '{0, 0, 0, 0, 1, 1}},
      '{1, 2,       8'h00, KindFill,   0, 1, NoRun},
      '{0, 0,       8'h01, KindFill,   0, 1, NoRun},
      '{0, 0,       8'h02, KindFill,   0, 1, '{1, 0, 2, 16'h0201, 0, 0}},
      '{0, 0,       8'hFF, KindFill,   0, 1, NoRun},
      '{0, 0,       8'h44, KindFill,   0, 1, '{0, 0, 0, 0, 0, 1}},
      '{0, 0,       8'h00, KindFill,   1, 1, '{0, 0, 0, 0, 1, 1}},
      '{1, 2097151, 8'hFF, KindFill,   1, 1, '{0, 0, 0, 0, 1, 0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rle16_req_if req_bus ();
   rle16_rsp_if rsp_bus ();
   rle16_csr_if csr_bus ();

   rle16_frame_pixel_decoder_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #(Period / 2) clock = ~clock;

   // decoder state mirror
   logic [FrameW-1:0] frame_cfg;
   phase_type         ph;
   logic [CountW-1:0] lit_left;
   logic              fill_pend;
   logic [CountW-1:0] fill_cnt;
   logic [ByteW-1:0]  low_byte;
   logic [PosW-1:0]   pos;
   logic              halted;
   logic              ovf;

   rsp_item_type pending_runs [$];
   int           bad_runs      = 0;
   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   int           hold_requests = 0;
   int           holds_done    = 0;
   int           hold_left     = 0;

   function automatic void clear_frame();
      ph        = PH_HEADER;
      lit_left  = '0;
      fill_pend = 1'b0;
      fill_cnt  = '0;
      low_byte  = '0;
      pos       = '0;
      halted    = 1'b0;
      ovf       = 1'b0;
   endfunction

   function automatic void open_header(input logic [ByteW-1:0] b, input logic kind);
      if (b[ByteW-1]) begin
         lit_left  = ~b + 8'd1;
         fill_pend = 1'b0;
         ph        = PH_LOW;
      end else if (kind == KindFill) begin
         fill_pend = 1'b1;
         fill_cnt  = b + 8'd2;
         ph        = PH_LOW;
      end else begin
         fill_pend = 1'b0;
         fill_cnt  = b + 8'd1;
         ph        = PH_SKIP;
      end
   endfunction

   function automatic rsp_item_type decode_word(input req_item_type w);
      rsp_item_type      r;
      logic [FrameW-1:0] fsize;
      logic [PosW-1:0]   room;
      logic [CountW-1:0] len;
      r     = '0;
      len   = '0;
      fsize = (frame_cfg > FrameMax) ? FrameMax : frame_cfg;
      if (!halted) begin
         case (ph)
            PH_HEADER: begin
               if (!w.last_byte) open_header(w.data_byte, w.frame_kind);
            end
            PH_LOW: begin
               if (w.last_byte) begin
                  halted = 1'b1;
               end else if (!fill_pend && pos >= fsize) begin
                  ovf    = 1'b1;
                  halted = 1'b1;
               end else begin
                  low_byte = w.data_byte;
                  ph       = PH_HIGH;
               end
            end
            PH_HIGH: begin
               r.color       = {w.data_byte, low_byte};
               r.start_pixel = pos[StartW-1:0];
               if (fill_pend) begin
                  if (pos >= fsize) begin
                     ovf = 1'b1;
                  end else begin
                     room = fsize - pos;
                     len  = fill_cnt;
                     if (PosW'(fill_cnt) > room) begin
                        len = CountW'(room);
                        ovf = 1'b1;
                     end
                  end
                  pos           = pos + PosW'(len);
                  r.write_valid = (len != '0);
                  fill_pend     = 1'b0;
                  ph            = PH_HEADER;
                  if (ovf) halted = 1'b1;
               end else begin
                  r.write_valid = 1'b1;
                  len           = CountW'(1);
                  pos           = pos + PosW'(1);
                  if (lit_left != '0) lit_left = lit_left - CountW'(1);
                  ph = (lit_left != '0) ? PH_LOW : PH_HEADER;
               end
            end
            PH_SKIP: begin
               if (w.last_byte) begin
                  halted = 1'b1;
               end else if (pos >= fsize) begin
                  ovf    = 1'b1;
                  halted = 1'b1;
               end else begin
                  pos = pos + PosW'(fill_cnt);
                  ph  = PH_HEADER;
                  open_header(w.data_byte, w.frame_kind);
               end
            end
            default: begin
               ph = PH_HEADER;
            end
         endcase
      end
      r.run_length = len;
      if (!r.write_valid) begin
         r.start_pixel = '0;
         r.run_length  = '0;
         r.color       = '0;
      end
      r.frame_end = w.last_byte;
      r.overflow  = ovf;
      if (w.last_byte) clear_frame();
      return r;
   endfunction

   // enter and leave on a falling edge; valid is left for the next call to drive
   task automatic send_word(input req_item_type w, input bit has_typed,
                            input rsp_item_type typed);
      rsp_item_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= w.data_byte;
      req_bus.frame_kind <= w.frame_kind;
      req_bus.last_byte  <= w.last_byte;
      do @(posedge clock); while (!req_bus.ready);
      pred = decode_word(w);
      pending_runs = {pending_runs, (has_typed ? typed : pred)};
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_runs.size() != 0) @(negedge clock);
      repeat (DrainPause) @(negedge clock);
   endtask

   task automatic write_frame_size(input logic [FrameW-1:0] value);
      drain_results();
      csr_bus.valid        <= 1'b1;
      csr_bus.frame_pixels <= value;
      do @(posedge clock); while (!csr_bus.ready);
      frame_cfg = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_frame(output int n);
      req_item_type words [$];
      req_item_type w;
      logic         kind;
      logic         hk;
      int           pick;
      int           cnt;
      kind = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 12))
            words = {words, req_item_type'{8'($urandom), 1'($urandom), 1'b0}};
      end else begin
         repeat ($urandom_range(1, 6)) begin
            hk = ($urandom_range(19) == 0) ? ~kind : kind;
            if ($urandom_range(99) < 40) begin
               cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
               words = {words, req_item_type'{8'(256 - cnt), hk, 1'b0}};
               repeat (2 * cnt) words = {words, req_item_type'{8'($urandom), kind, 1'b0}};
            end else begin
               cnt = ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
               words = {words, req_item_type'{8'(cnt), hk, 1'b0}};
               if (hk == KindFill)
                  repeat (2) words = {words, req_item_type'{8'($urandom), kind, 1'b0}};
            end
         end
         // truncate some frames mid-command
         if (pick < 30) begin
            cnt = $urandom_range(1, words.size());
            while (words.size() > cnt) void'(words.pop_back());
         end
      end
      w           = words.pop_back();
      w.last_byte = 1'b1;
      words       = {words, w};
      foreach (words[i]) send_word(words[i], 1'b0, NoRun);
      n = words.size();
   endtask

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HoldCycles;
         holds_done    <= holds_done + 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_runs
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.write_valid, rsp_bus.start_pixel, rsp_bus.run_length,
                 rsp_bus.color, rsp_bus.frame_end, rsp_bus.overflow};
         if (pending_runs.size() == 0) begin
            if (bad_runs < 10) $display("unexpected run word: %p", got);
            bad_runs++;
         end else begin
            want = pending_runs.pop_front();
            if (got !== want) begin
               if (bad_runs < 10) $display("run word mismatch: want %p got %p", want, got);
               bad_runs++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("rle16_frame_pixel_decoder_core test failed");
      $finish;
   end

   initial begin : stimulus
      int  sent;
      int  n;
      bit  paused;
      req_bus.valid        = 1'b0;
      req_bus.data_byte    = '0;
      req_bus.frame_kind   = KindFill;
      req_bus.last_byte    = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.frame_pixels = '0;
      frame_cfg            = FrameReset;
      clear_frame();
      paused = 1'b0;

      repeat (ResetLen) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script_rows[i]) begin
         if (script_rows[i].set_size) write_frame_size(FrameW'(script_rows[i].size));
         send_word(req_item_type'{script_rows[i].data, script_rows[i].kind,
                                  script_rows[i].last},
                   script_rows[i].typed, script_rows[i].want);
      end

      for (int p = 0; p < NumPhases; p++) begin
         write_frame_size(FrameW'(PhaseSizes[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         // back up the block while the sender keeps offering words
         if (p == 0) hold_requests++;
         sent = 0;
         while (sent < PhaseWords) begin
            if (p == 5 && !paused && sent >= PhaseWords / 2) begin
               drain_results();
               paused = 1'b1;
            end
            send_frame(n);
            sent += n;
         end
      end

      drain_results();
      if (bad_runs == 0)
         $display("rle16_frame_pixel_decoder_core test passed");
      else
         $display("rle16_frame_pixel_decoder_core test failed");
      $finish;
   end

endmodule
`default_nettype wire
